FILE: rtl/core/ihtt_pkg.sv
// Shared constants and types for the identifier hash to token block.
package ihtt_pkg;

  // Field and datapath widths
  localparam int HashW  = 32;
  localparam int DivW   = HashW - 1;
  localparam int ByteW  = 8;
  localparam int TokenW = 16;
  localparam int CntW   = $clog2(DivW + 1);

  // Hash arithmetic constants
  localparam logic [HashW-1:0] HashMul   = 32'd8209;
  localparam logic [HashW-1:0] ByteMul   = 32'd613;
  localparam logic [HashW-1:0] NegFix    = 32'd2147483647;
  localparam logic [ByteW-1:0] SpaceByte = 8'h20;

  // Configuration register reset values and indexes
  localparam logic [TokenW-1:0] RegularReset = 16'd256;
  localparam logic [TokenW-1:0] TotalReset   = 16'd1024;
  localparam logic RegIdxRegular = 1'b0;
  localparam logic RegIdxTotal   = 1'b1;

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Finished hash handed from the front to the queue
  typedef struct packed {
    logic            push;
    logic [DivW-1:0] hash;
  } hash_push_t;

endpackage

FILE: rtl/core/ihtt_char_if.sv
// Channel carrying identifier bytes and the end marker.
interface ihtt_char_if;
  logic                          valid;
  logic                          ready;
  logic [ihtt_pkg::ByteW-1:0]    char_byte;
  logic                          end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink (input valid, input char_byte, input end_of_string, output ready);
endinterface

FILE: rtl/core/ihtt_token_if.sv
// Channel carrying token numbers.
interface ihtt_token_if;
  logic                          valid;
  logic                          ready;
  logic [ihtt_pkg::TokenW-1:0]   token_number;

  modport source (output valid, output token_number, input ready);
  modport sink (input valid, input token_number, output ready);
endinterface

FILE: rtl/core/ihtt_front.sv
// Front end: accepts bytes, keeps the running hash, hands finished hashes on.
module ihtt_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [ihtt_pkg::ByteW-1:0] char_byte,
  input  logic                       end_of_string,
  input  logic                       queue_full,
  output logic                       in_ready,
  output ihtt_pkg::hash_push_t       push
);

  logic [ihtt_pkg::HashW-1:0] running_hash;
  logic [ihtt_pkg::HashW-1:0] mixed;
  logic [ihtt_pkg::HashW-1:0] running_hash_next;
  logic                       accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Mix one byte into the hash, folding negative results back
  always_comb begin
    mixed = running_hash * ihtt_pkg::HashMul
          + ihtt_pkg::HashW'(char_byte) * ihtt_pkg::ByteMul;
    if (mixed[ihtt_pkg::HashW-1]) begin
      running_hash_next = mixed + ihtt_pkg::NegFix;
    end else begin
      running_hash_next = mixed;
    end
  end

  // Push the clamped hash on an end transaction
  always_comb begin
    push.push = accept && end_of_string;
    if (running_hash[ihtt_pkg::HashW-1]) begin
      push.hash = '0;
    end else begin
      push.hash = running_hash[ihtt_pkg::DivW-1:0];
    end
  end

  // Advance the hash; clear it at the end of each identifier
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (accept) begin
      if (end_of_string) begin
        running_hash <= '0;
      end else if (char_byte != ihtt_pkg::SpaceByte) begin
        running_hash <= running_hash_next;
      end
    end
  end

endmodule

FILE: rtl/core/ihtt_queue.sv
// Short queue of finished hashes between front and back.
module ihtt_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  ihtt_pkg::hash_push_t       push,
  output logic                       full,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ihtt_pkg::DivW-1:0]  out_hash
);

  logic [ihtt_pkg::DivW-1:0]      mem [ihtt_pkg::QueueDepth];
  logic [ihtt_pkg::QueuePtrW-1:0] wr_ptr;
  logic [ihtt_pkg::QueuePtrW-1:0] rd_ptr;
  logic [ihtt_pkg::QueueCntW-1:0] count;
  logic                           pop;

  assign full      = (count == ihtt_pkg::QueueCntW'(ihtt_pkg::QueueDepth));
  assign out_valid = (count != '0);
  assign out_hash  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Store pushed hashes
  always_ff @(posedge clk) begin
    if (push.push) begin
      mem[wr_ptr] <= push.hash;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ihtt_back.sv
// Back end: reduces a hash modulo the token range, one quotient bit a cycle.
module ihtt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [ihtt_pkg::DivW-1:0]   q_hash,
  input  logic [ihtt_pkg::TokenW-1:0] regular_token_count,
  input  logic [ihtt_pkg::TokenW-1:0] total_token_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ihtt_pkg::TokenW-1:0] token_number
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

  state_t                      state;
  logic [ihtt_pkg::DivW-1:0]   dividend;
  logic [ihtt_pkg::TokenW-1:0] remainder;
  logic [ihtt_pkg::TokenW-1:0] modulus;
  logic [ihtt_pkg::CntW-1:0]   steps;
  logic signed [ihtt_pkg::TokenW+1:0] diff;
  logic [ihtt_pkg::TokenW-1:0] modulus_next;
  logic [ihtt_pkg::TokenW:0]   shifted;
  logic [ihtt_pkg::TokenW:0]   reduced;

  assign q_ready   = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // Modulus is total minus regular minus one, at least one
  always_comb begin
    diff = $signed({2'b00, total_token_count}) - $signed({2'b00, regular_token_count})
         - 18'sd1;
    if (diff < 18'sd1) begin
      modulus_next = ihtt_pkg::TokenW'(1);
    end else begin
      modulus_next = diff[ihtt_pkg::TokenW-1:0];
    end
  end

  // One restoring division step
  always_comb begin
    shifted = {remainder, dividend[ihtt_pkg::DivW-1]};
    if (shifted >= {1'b0, modulus}) begin
      reduced = shifted - {1'b0, modulus};
    end else begin
      reduced = shifted;
    end
  end

  // Sequence load, divide and hold of the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            dividend  <= q_hash;
            remainder <= '0;
            modulus   <= modulus_next;
            steps     <= ihtt_pkg::CntW'(ihtt_pkg::DivW);
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          dividend  <= {dividend[ihtt_pkg::DivW-2:0], 1'b0};
          remainder <= reduced[ihtt_pkg::TokenW-1:0];
          steps     <= steps - 1'b1;
          if (steps == ihtt_pkg::CntW'(1)) begin
            token_number <= reduced[ihtt_pkg::TokenW-1:0] + regular_token_count;
            state        <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/identifier_hash_to_token_core.sv
// Identifier hash to token: top level with configuration registers.
//
// Usage: bytes of one identifier arrive on the chars channel, one per
// transaction, with end_of_string low. Spaces leave the hash unchanged.
// A transaction with end_of_string high closes the identifier; its
// char_byte is ignored, and one token_number then leaves on the tokens
// channel. Byte transactions produce nothing.
// Throughput: the front takes one byte per cycle while the hash queue
// (two entries) has room. Each end transaction passes through the back
// in order: a load, 31 restoring division steps (one quotient bit a
// cycle in the shared subtract and compare), then the token is presented.
// When the receiver stalls, the token is held in the output register and
// the back waits; further identifiers queue up to two, after which
// chars.ready drops.
// Reset (rst, synchronous) clears the running hash and the queue, and sets
// regular_token_count to 256 and total_token_count to 1024. Registers are
// written over the APB port at byte addresses 0 and 4. The user must
// write them only while idle; the block itself does not enforce this.
module identifier_hash_to_token_core (
  input  logic                clk,
  input  logic                rst,
  ihtt_char_if.sink           chars,
  ihtt_token_if.source        tokens,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [ihtt_pkg::TokenW-1:0] regular_token_count;
  logic [ihtt_pkg::TokenW-1:0] total_token_count;
  logic                        reg_sel;
  logic                        cfg_write;
  ihtt_pkg::hash_push_t        push;
  logic                        queue_full;
  logic                        q_valid;
  logic                        q_ready;
  logic [ihtt_pkg::DivW-1:0]   q_hash;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regular_token_count <= ihtt_pkg::RegularReset;
      total_token_count   <= ihtt_pkg::TotalReset;
    end else if (cfg_write) begin
      case (reg_sel)
        ihtt_pkg::RegIdxRegular: regular_token_count <= pwdata[ihtt_pkg::TokenW-1:0];
        ihtt_pkg::RegIdxTotal:   total_token_count   <= pwdata[ihtt_pkg::TokenW-1:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (reg_sel)
      ihtt_pkg::RegIdxRegular: prdata = {16'h0000, regular_token_count};
      ihtt_pkg::RegIdxTotal:   prdata = {16'h0000, total_token_count};
      default:                 prdata = '0;
    endcase
  end

  ihtt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (chars.valid),
    .char_byte     (chars.char_byte),
    .end_of_string (chars.end_of_string),
    .queue_full    (queue_full),
    .in_ready      (chars.ready),
    .push          (push)
  );

  ihtt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (queue_full),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_hash  (q_hash)
  );

  ihtt_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_ready             (q_ready),
    .q_hash              (q_hash),
    .regular_token_count (regular_token_count),
    .total_token_count   (total_token_count),
    .out_valid           (tokens.valid),
    .out_ready           (tokens.ready),
    .token_number        (tokens.token_number)
  );

endmodule

FILE: sim/identifier_hash_to_token_core_test.sv
// Self-checking testbench for the identifier hash to token core.
module identifier_hash_to_token_core_test;

  localparam int          WatchdogLimit = 5000;
  localparam int          SettleCycles  = 40;
  localparam int          PhaseItems    = 112;
  localparam logic [2:0]  AddrRegular   = {ihtt_pkg::RegIdxRegular, 2'b00};
  localparam logic [2:0]  AddrTotal     = {ihtt_pkg::RegIdxTotal, 2'b00};

  typedef struct packed {
    logic [ihtt_pkg::ByteW-1:0] char_byte;
    logic                       end_of_string;
  } char_txn_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  ihtt_char_if  chars_if ();
  ihtt_token_if tokens_if ();

  identifier_hash_to_token_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .tokens  (tokens_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus, prediction and bookkeeping
  char_txn_t                   pending_chars[$];
  logic [ihtt_pkg::TokenW-1:0] expected_tokens[$];
  char_txn_t                   next_char;
  logic [ihtt_pkg::HashW-1:0]  ident_hash;
  logic [ihtt_pkg::TokenW-1:0] regular_cnt;
  logic [ihtt_pkg::TokenW-1:0] total_cnt;
  logic [ihtt_pkg::TokenW-1:0] wanted_token;
  logic              char_taken;
  int                gap_pct;
  int                mismatches;
  int                tokens_checked;
  int                chars_sent;
  int                quiet_cycles;
  int                phase_items;
  int                settings_run;

  // Clock: period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hash one non-space byte into the running value
  function automatic logic [ihtt_pkg::HashW-1:0] mix_char(
    input logic [ihtt_pkg::HashW-1:0] h,
    input logic [ihtt_pkg::ByteW-1:0] b
  );
    logic [ihtt_pkg::HashW-1:0] n;
    n = h * 32'd8209 + {24'd0, b} * 32'd613;
    if (n[ihtt_pkg::HashW-1]) n = n + 32'd2147483647;
    return n;
  endfunction

  // Reduce a finished hash to a token number under the current registers
  function automatic logic [ihtt_pkg::TokenW-1:0] hash_to_token(
    input logic [ihtt_pkg::HashW-1:0] h
  );
    int                         m;
    logic [ihtt_pkg::HashW-1:0] hv;
    logic [ihtt_pkg::HashW-1:0] rem;
    m  = int'({16'd0, total_cnt}) - int'({16'd0, regular_cnt}) - 1;
    hv = h[ihtt_pkg::HashW-1] ? '0 : h;
    if (m < 1) m = 1;
    rem = hv % 32'(m);
    return ihtt_pkg::TokenW'(rem + {16'd0, regular_cnt});
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Driver: present the next byte transaction at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else if (!chars_if.valid || char_taken) begin
      if (pending_chars.size() > 0 && $urandom_range(99) >= gap_pct) begin
        next_char = pending_chars.pop_front();
        chars_if.valid         <= 1'b1;
        chars_if.char_byte     <= next_char.char_byte;
        chars_if.end_of_string <= next_char.end_of_string;
      end else begin
        chars_if.valid <= 1'b0;
      end
    end
    tokens_if.ready <= ($urandom_range(99) >= gap_pct);
  end

  // Monitor: predict on accepted bytes, check accepted tokens, guard progress
  always @(posedge clk) begin
    char_taken = 1'b0;
    if (!rst) begin
      quiet_cycles++;
      if (chars_if.valid && chars_if.ready) begin
        char_taken   = 1'b1;
        quiet_cycles = 0;
        chars_sent++;
        if (chars_if.end_of_string) begin
          expected_tokens.push_back(hash_to_token(ident_hash));
          ident_hash = '0;
        end else if (chars_if.char_byte != ihtt_pkg::SpaceByte) begin
          ident_hash = mix_char(ident_hash, chars_if.char_byte);
        end
      end
      if (tokens_if.valid && tokens_if.ready) begin
        quiet_cycles = 0;
        if (expected_tokens.size() == 0) begin
          flag_mismatch($sformatf("token %0d with none outstanding",
                                  tokens_if.token_number));
        end else begin
          wanted_token = expected_tokens.pop_front();
          tokens_checked++;
          if (tokens_if.token_number !== wanted_token)
            flag_mismatch($sformatf("token_number %0d, expected %0d",
                                    tokens_if.token_number, wanted_token));
        end
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input logic [2:0] addr,
                           input logic [ihtt_pkg::TokenW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrRegular) regular_cnt = value;
    else total_cnt = value;
  endtask

  task automatic set_token_space(input logic [ihtt_pkg::TokenW-1:0] regular,
                                 input logic [ihtt_pkg::TokenW-1:0] total);
    write_reg(AddrRegular, regular);
    write_reg(AddrTotal, total);
    settings_run++;
  endtask

  // Hold until every byte is taken and every token has returned, then settle
  task automatic drain();
    while (pending_chars.size() > 0 || chars_if.valid || expected_tokens.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic push_char(input logic [ihtt_pkg::ByteW-1:0] b, input logic eos);
    char_txn_t t;
    t.char_byte     = b;
    t.end_of_string = eos;
    pending_chars.push_back(t);
    phase_items++;
  endtask

  // Mostly identifier-like bytes, with spaces and arbitrary bytes mixed in
  function automatic logic [ihtt_pkg::ByteW-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 15) return ihtt_pkg::SpaceByte;
    if (r < 40) return ihtt_pkg::ByteW'($urandom_range(255));
    if (r < 75) return ihtt_pkg::ByteW'($urandom_range(8'h7a, 8'h61));
    if (r < 90) return ihtt_pkg::ByteW'($urandom_range(8'h5a, 8'h41));
    return ihtt_pkg::ByteW'($urandom_range(8'h39, 8'h30));
  endfunction

  task automatic push_identifier();
    int len;
    int r;
    r = $urandom_range(99);
    if (r < 5) len = 0;
    else if (r < 90) len = $urandom_range(10, 1);
    else len = $urandom_range(30, 11);
    for (int i = 0; i < len; i++) push_char(pick_char(), 1'b0);
    push_char(ihtt_pkg::ByteW'($urandom_range(255)), 1'b1);
  endtask

  task automatic random_phase(input int gaps);
    gap_pct     = gaps;
    phase_items = 0;
    while (phase_items < PhaseItems) push_identifier();
    drain();
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    chars_if.valid         = 1'b0;
    chars_if.char_byte     = '0;
    chars_if.end_of_string = 1'b0;
    tokens_if.ready        = 1'b0;
    ident_hash     = '0;
    regular_cnt    = ihtt_pkg::RegularReset;
    total_cnt      = ihtt_pkg::TotalReset;
    char_taken     = 1'b0;
    gap_pct        = 9;
    mismatches     = 0;
    tokens_checked = 0;
    chars_sent     = 0;
    quiet_cycles   = 0;
    phase_items    = 0;
    settings_run   = 1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed identifiers under the reset register values
    push_char(8'h00, 1'b1);                     // empty identifier
    push_char(ihtt_pkg::SpaceByte, 1'b0);       // spaces only
    push_char(ihtt_pkg::SpaceByte, 1'b0);
    push_char(8'h55, 1'b1);
    push_char(8'h00, 1'b0);                     // zero byte hashes, does not end
    push_char(8'hAA, 1'b1);
    repeat (4) push_char(8'hFF, 1'b0);          // large bytes drive the hash negative
    push_char(8'hFF, 1'b1);
    push_char(8'h61, 1'b0);
    push_char(ihtt_pkg::SpaceByte, 1'b0);
    push_char(8'h5F, 1'b0);
    push_char(ihtt_pkg::SpaceByte, 1'b0);
    push_char(8'h7A, 1'b0);
    push_char(8'h01, 1'b1);
    push_char(8'h80, 1'b0);
    push_char(8'h7F, 1'b0);
    push_char(8'h55, 1'b0);
    push_char(8'hAA, 1'b0);
    push_char(8'h30, 1'b1);
    drain();

    // Sweep register settings, extremes and degenerate moduli among them
    set_token_space(16'd0, 16'd65535);
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b0);
    push_char(8'hFF, 1'b1);
    random_phase(9);
    set_token_space(16'd65535, 16'd0);
    random_phase(9);
    set_token_space(16'd1000, 16'd1001);
    random_phase(0);
    set_token_space(16'd5, 16'd7);
    random_phase(9);
    set_token_space(16'd0, 16'd1);
    random_phase(9);
    set_token_space(16'd65535, 16'd65535);
    random_phase(9);
    set_token_space(16'($urandom_range(4000)), 16'($urandom_range(65535, 4000)));
    random_phase(9);
    set_token_space(16'($urandom), 16'($urandom));
    random_phase(9);
    set_token_space(ihtt_pkg::RegularReset, ihtt_pkg::TotalReset);
    random_phase(9);

    $display("covered %0d byte transactions, %0d tokens checked, %0d register settings",
             chars_sent, tokens_checked, settings_run);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
